### src/lpss_pkg.sv
// ----------------------------------------------------------------------------
// lpss_pkg
// Shared constants, command codes and the decoded command word for the LED
// PWM level store.
// ----------------------------------------------------------------------------
package lpss_pkg;

  localparam int DEVICES     = 1;
  localparam int CH_PER_DEV  = 24;
  localparam int TOTAL       = DEVICES * CH_PER_DEV;
  localparam int LEDS        = TOTAL / 3;
  localparam int IDX_W       = $clog2(TOTAL);
  localparam int CNT_W       = $clog2(TOTAL + 1);
  localparam int LVL_W       = 12;
  localparam int VAL_W       = 16;
  localparam int CHAN_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int SHCH_W      = 6;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [LVL_W-1:0] LEVEL_MAX = 12'h0FFF;

  localparam logic [2:0] OP_SET1   = 3'd0;
  localparam logic [2:0] OP_GET1   = 3'd1;
  localparam logic [2:0] OP_SETRGB = 3'd2;
  localparam logic [2:0] OP_GETRGB = 3'd3;
  localparam logic [2:0] OP_SETALL = 3'd4;
  localparam logic [2:0] OP_SHIFT  = 3'd5;

  typedef enum logic [2:0] {
    K_ERR, K_SET1, K_GET1, K_SETRGB, K_GETRGB, K_SETALL, K_SHIFT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic [LVL_W-1:0]  lvl_a;
    logic [LVL_W-1:0]  lvl_b;
    logic [LVL_W-1:0]  lvl_c;
  } cmd_t;

  function automatic logic [LVL_W-1:0] sat_level(input logic [VAL_W-1:0] v);
    sat_level = (v > VAL_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LVL_W-1:0];
  endfunction

endpackage

### src/lpss_ram.sv
// ----------------------------------------------------------------------------
// lpss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpss_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lpss_front.sv
// ----------------------------------------------------------------------------
// lpss_front
// Command decode: range checks, level saturation, count clamp, and drop of
// unused opcodes and negative counts.
// ----------------------------------------------------------------------------
module lpss_front (
  input  logic                          accept,
  input  logic [2:0]                    op,
  input  logic [lpss_pkg::CHAN_W-1:0]   channel,
  input  logic [lpss_pkg::VAL_W-1:0]    value_r,
  input  logic [lpss_pkg::VAL_W-1:0]    value_g,
  input  logic [lpss_pkg::VAL_W-1:0]    value_b,
  input  logic signed [lpss_pkg::COUNT_W-1:0] count,
  output logic                          push,
  output lpss_pkg::cmd_t                cmd
);

  logic                        keep;
  logic [lpss_pkg::CHAN_W+1:0] base;

  // LED index times three
  assign base = {2'b00, channel} + {1'b0, channel, 1'b0};

  always_comb begin
    keep      = 1'b1;
    cmd.kind  = lpss_pkg::K_ERR;
    cmd.idx   = channel[lpss_pkg::IDX_W-1:0];
    cmd.cnt   = lpss_pkg::CNT_W'(lpss_pkg::TOTAL);
    cmd.lvl_a = lpss_pkg::sat_level(value_r);
    cmd.lvl_b = lpss_pkg::sat_level(value_g);
    cmd.lvl_c = lpss_pkg::sat_level(value_b);
    unique case (op)
      lpss_pkg::OP_SET1, lpss_pkg::OP_GET1: begin
        if (channel >= lpss_pkg::CHAN_W'(lpss_pkg::TOTAL)) begin
          cmd.kind = lpss_pkg::K_ERR;
        end else begin
          cmd.kind = (op == lpss_pkg::OP_SET1) ? lpss_pkg::K_SET1 : lpss_pkg::K_GET1;
        end
      end
      lpss_pkg::OP_SETRGB, lpss_pkg::OP_GETRGB: begin
        cmd.idx = base[lpss_pkg::IDX_W-1:0];
        if (channel >= lpss_pkg::CHAN_W'(lpss_pkg::LEDS)) begin
          cmd.kind = lpss_pkg::K_ERR;
        end else begin
          cmd.kind = (op == lpss_pkg::OP_SETRGB) ? lpss_pkg::K_SETRGB
                                                 : lpss_pkg::K_GETRGB;
        end
      end
      lpss_pkg::OP_SETALL: begin
        cmd.kind = lpss_pkg::K_SETALL;
      end
      lpss_pkg::OP_SHIFT: begin
        cmd.kind = lpss_pkg::K_SHIFT;
        keep     = !count[lpss_pkg::COUNT_W-1];
        if (count[lpss_pkg::COUNT_W-2:0] > (lpss_pkg::COUNT_W-1)'(lpss_pkg::TOTAL)) begin
          cmd.cnt = lpss_pkg::CNT_W'(lpss_pkg::TOTAL);
        end else begin
          cmd.cnt = count[lpss_pkg::CNT_W-1:0];
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

### src/lpss_queue.sv
// ----------------------------------------------------------------------------
// lpss_queue
// Short FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module lpss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpss_pkg::cmd_t din,
  input  logic           pop,
  output lpss_pkg::cmd_t dout,
  output logic           empty,
  output logic           full
);

  lpss_pkg::cmd_t              ent [lpss_pkg::QDEPTH];
  logic [lpss_pkg::QPTR_W-1:0] wr_ptr;
  logic [lpss_pkg::QPTR_W-1:0] rd_ptr;
  logic [lpss_pkg::QCNT_W-1:0] fill;

  function automatic logic [lpss_pkg::QPTR_W-1:0] bump(input logic [lpss_pkg::QPTR_W-1:0] p);
    bump = (p == lpss_pkg::QPTR_W'(lpss_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (fill == '0);
  assign full  = (fill == lpss_pkg::QCNT_W'(lpss_pkg::QDEPTH));
  assign dout  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

endmodule

### src/lpss_back.sv
// ----------------------------------------------------------------------------
// lpss_back
// Command sequencer: walks the level store one entry a cycle and drives the
// registered result words.
// ----------------------------------------------------------------------------
module lpss_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  lpss_pkg::cmd_t                q_head,
  output logic                          pop,
  output logic                          strobe,
  output logic                          status,
  output logic [lpss_pkg::LVL_W-1:0]    word_a,
  output logic [lpss_pkg::LVL_W-1:0]    word_b,
  output logic [lpss_pkg::LVL_W-1:0]    word_c,
  output logic                          shift_valid,
  output logic [lpss_pkg::SHCH_W-1:0]   shift_channel,
  output logic                          latch,
  output logic                          last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic                        emit;
    logic                        cap_a;
    logic                        cap_b;
    logic                        use_rd;
    logic                        rgb;
    logic                        status;
    logic [lpss_pkg::LVL_W-1:0]  word_a;
    logic                        sv;
    logic [lpss_pkg::IDX_W-1:0]  ch;
    logic                        latch;
    logic                        last;
  } pend_t;

  state_t                      state, state_next;
  lpss_pkg::cmd_t              cur;
  logic [lpss_pkg::IDX_W-1:0]  ptr, ptr_next, ptr_init;
  logic [1:0]                  step, step_next;
  logic                        done;
  pend_t                       pend, pend_next;

  logic                        we, re;
  logic [lpss_pkg::IDX_W-1:0]  waddr, raddr;
  logic [lpss_pkg::LVL_W-1:0]  wdata, rdata, rdv;
  logic [lpss_pkg::TOTAL-1:0]  vld;
  logic                        vld_q;
  logic [lpss_pkg::LVL_W-1:0]  hold_a, hold_b;

  lpss_ram #(
    .WIDTH(lpss_pkg::LVL_W),
    .DEPTH(lpss_pkg::TOTAL)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // never-written entries read as zero
  assign rdv = vld_q ? rdata : '0;

  always_comb begin
    unique case (q_head.kind)
      lpss_pkg::K_SETALL: ptr_init = lpss_pkg::IDX_W'(lpss_pkg::TOTAL - 1);
      lpss_pkg::K_SHIFT:  ptr_init = (q_head.cnt == '0) ? '0
                                   : lpss_pkg::IDX_W'(q_head.cnt - 1'b1);
      default:            ptr_init = q_head.idx;
    endcase
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    step_next  = step;
    pop        = 1'b0;
    done       = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = ptr;
    raddr      = ptr;
    wdata      = cur.lvl_a;
    pend_next  = '0;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          ptr_next   = ptr_init;
          step_next  = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        unique case (cur.kind)
          lpss_pkg::K_ERR: begin
            pend_next.emit   = 1'b1;
            pend_next.status = 1'b1;
            pend_next.last   = 1'b1;
            done             = 1'b1;
          end
          lpss_pkg::K_SET1: begin
            we             = 1'b1;
            pend_next.emit = 1'b1;
            pend_next.last = 1'b1;
            done           = 1'b1;
          end
          lpss_pkg::K_GET1: begin
            re               = 1'b1;
            pend_next.emit   = 1'b1;
            pend_next.use_rd = 1'b1;
            pend_next.last   = 1'b1;
            done             = 1'b1;
          end
          lpss_pkg::K_SETRGB: begin
            we        = 1'b1;
            wdata     = (step == 2'd0) ? cur.lvl_a :
                        (step == 2'd1) ? cur.lvl_b : cur.lvl_c;
            ptr_next  = ptr + 1'b1;
            step_next = step + 1'b1;
            if (step == 2'd2) begin
              pend_next.emit = 1'b1;
              pend_next.last = 1'b1;
              done           = 1'b1;
            end
          end
          lpss_pkg::K_GETRGB: begin
            re              = 1'b1;
            ptr_next        = ptr + 1'b1;
            step_next       = step + 1'b1;
            pend_next.cap_a = (step == 2'd0);
            pend_next.cap_b = (step == 2'd1);
            if (step == 2'd2) begin
              pend_next.emit = 1'b1;
              pend_next.rgb  = 1'b1;
              pend_next.last = 1'b1;
              done           = 1'b1;
            end
          end
          lpss_pkg::K_SETALL: begin
            we               = 1'b1;
            pend_next.emit   = 1'b1;
            pend_next.word_a = cur.lvl_a;
            pend_next.sv     = 1'b1;
            pend_next.ch     = ptr;
            pend_next.latch  = (ptr == '0);
            pend_next.last   = (ptr == '0);
            done             = (ptr == '0);
            ptr_next         = ptr - 1'b1;
          end
          lpss_pkg::K_SHIFT: begin
            pend_next.emit  = 1'b1;
            pend_next.latch = (ptr == '0);
            pend_next.last  = (ptr == '0);
            done            = (ptr == '0);
            if (cur.cnt != '0) begin
              re               = 1'b1;
              pend_next.use_rd = 1'b1;
              pend_next.sv     = 1'b1;
              pend_next.ch     = ptr;
              ptr_next         = ptr - 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= '0;
      vld    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      strobe <= pend.emit;
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    step <= step_next;
    if (pop) begin
      cur <= q_head;
    end
    if (re) begin
      vld_q <= vld[raddr];
    end
    if (pend.cap_a) begin
      hold_a <= rdv;
    end
    if (pend.cap_b) begin
      hold_b <= rdv;
    end
    status        <= pend.status;
    word_a        <= pend.rgb ? hold_a : (pend.use_rd ? rdv : pend.word_a);
    word_b        <= pend.rgb ? hold_b : '0;
    word_c        <= pend.rgb ? rdv : '0;
    shift_valid   <= pend.sv;
    shift_channel <= lpss_pkg::SHCH_W'(pend.ch);
    latch         <= pend.latch;
    last          <= pend.last;
  end

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(we && re))
    else $error("store read and written in the same cycle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("store written while idle");

  a_latch_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && latch) |-> last)
    else $error("latch pulse on a result that is not last");

  a_chan0_latches: assert property (@(posedge clk) disable iff (rst)
    (strobe && shift_valid && shift_channel == '0) |-> latch)
    else $error("shift of channel zero without latch");

endmodule

### src/led_pwm_level_store_shift_out.sv
// ----------------------------------------------------------------------------
// led_pwm_level_store_shift_out
// 12-bit PWM level store with command decode, command queue and shift-out.
// ----------------------------------------------------------------------------
// A taken command passes the queue, the sequencer and its pend register, and
// its result is registered once more onto strobe. The back end walks the store
// one word per cycle and pops the next command only after the last one is done.
// A 2-deep queue takes commands while the back end works; busy means full.
// Reset (rst, synchronous) empties the queue and clears all levels to zero.
module led_pwm_level_store_shift_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         op,
  input  logic [lpss_pkg::CHAN_W-1:0]        channel,
  input  logic [lpss_pkg::VAL_W-1:0]         value_r,
  input  logic [lpss_pkg::VAL_W-1:0]         value_g,
  input  logic [lpss_pkg::VAL_W-1:0]         value_b,
  input  logic signed [lpss_pkg::COUNT_W-1:0] count,
  output logic                               strobe,
  output logic                               status,
  output logic [lpss_pkg::LVL_W-1:0]         word_a,
  output logic [lpss_pkg::LVL_W-1:0]         word_b,
  output logic [lpss_pkg::LVL_W-1:0]         word_c,
  output logic                               shift_valid,
  output logic [lpss_pkg::SHCH_W-1:0]        shift_channel,
  output logic                               latch,
  output logic                               last
);

  logic           push, pop, q_empty, q_full;
  lpss_pkg::cmd_t cmd, q_head;

  assign busy = q_full;

  lpss_front u_front (
    .accept (start && !busy),
    .op     (op),
    .channel(channel),
    .value_r(value_r),
    .value_g(value_g),
    .value_b(value_b),
    .count  (count),
    .push   (push),
    .cmd    (cmd)
  );

  lpss_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd),
    .pop  (pop),
    .dout (q_head),
    .empty(q_empty),
    .full (q_full)
  );

  lpss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .strobe       (strobe),
    .status       (status),
    .word_a       (word_a),
    .word_b       (word_b),
    .word_c       (word_c),
    .shift_valid  (shift_valid),
    .shift_channel(shift_channel),
    .latch        (latch),
    .last         (last)
  );

endmodule
